/* src/lfr_pkg.sv */
// ----------------------------------------------------------------------------
// LIN frame receiver package
// Status codes, the result descriptor and the LIN checksum and parity helpers.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_BREAK     = 3'd1;
    localparam logic [2:0] ST_SYNC_OK   = 3'd2;
    localparam logic [2:0] ST_ID_OK     = 3'd3;
    localparam logic [2:0] ST_STORED    = 3'd4;
    localparam logic [2:0] ST_DATA      = 3'd5;
    localparam logic [2:0] ST_MISMATCH  = 3'd6;
    localparam logic [2:0] ST_CHK_BAD   = 3'd7;

    localparam logic [1:0] REG_IDENT    = 2'd0;
    localparam logic [1:0] REG_DATA_LEN = 2'd1;
    localparam logic [1:0] REG_CHK_MODE = 2'd2;

    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_ENHANCED = 2'd1;

    localparam logic [7:0] BREAK_BYTE   = 8'h00;
    localparam logic [7:0] SYNC_BYTE    = 8'h55;
    localparam logic [5:0] FIRST_DIAG_ID = 6'h3C;

    // One result descriptor: a single status, or a burst of count data bytes.
    typedef struct packed {
        logic [2:0] status;
        logic       burst;
        logic [3:0] count;
    } lfr_result_t;

    // Protected identifier: frame ID with parity bits P0 (bit 6) and P1 (bit 7).
    function automatic logic [7:0] prot_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Eight-bit add with end-around carry.
    function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

endpackage

/* src/lfr_frame_fsm.sv */
// ----------------------------------------------------------------------------
// LIN frame receiver frame sequencer
// Tracks break, sync, protected ID, data and checksum per received byte.
// ----------------------------------------------------------------------------
module lfr_frame_fsm
    import lfr_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8,
    parameter int IDX_W          = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [5:0]        cfg_wdata,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output lfr_result_t       result,
    output logic [7:0]        store [MAX_DATA_BYTES]
);

    typedef enum logic [2:0] {
        PH_BREAK,
        PH_SYNC,
        PH_PID,
        PH_DATA,
        PH_CHK
    } phase_t;

    localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

    phase_t     phase_reg, phase_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [5:0] ident_reg;
    logic [3:0] data_len_reg;
    logic [1:0] chk_mode_reg;
    logic [7:0] store_reg [MAX_DATA_BYTES];
    logic       store_we;

    logic       length_ok;
    logic       enhanced;
    logic [7:0] pid;
    logic [7:0] chk_sum;
    logic [3:0] count_inc;

    assign length_ok = (data_len_reg >= 4'd1) && (data_len_reg <= MAX_LEN);
    assign pid       = prot_id(ident_reg);
    assign count_inc = count_reg + 4'd1;

    always_comb begin
        unique case (chk_mode_reg)
            MODE_ENHANCED: enhanced = 1'b1;
            MODE_AUTO:     enhanced = (ident_reg < FIRST_DIAG_ID);
            default:       enhanced = 1'b0;
        endcase
        chk_sum = enhanced ? carry_add(sum_reg, pid) : sum_reg;
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        result     = '{status: ST_IGNORED, burst: 1'b0, count: 4'd1};
        unique case (phase_reg)
            PH_BREAK: begin
                if (rx_byte == BREAK_BYTE) begin
                    phase_next    = PH_SYNC;
                    result.status = ST_BREAK;
                end
            end
            PH_SYNC: begin
                if (rx_byte == SYNC_BYTE) begin
                    phase_next    = PH_PID;
                    result.status = ST_SYNC_OK;
                end else begin
                    phase_next    = PH_BREAK;
                    count_next    = 4'd0;
                    sum_next      = 8'd0;
                    result.status = ST_MISMATCH;
                end
            end
            PH_PID: begin
                count_next = 4'd0;
                sum_next   = 8'd0;
                if (rx_byte == pid && length_ok) begin
                    phase_next    = PH_DATA;
                    result.status = ST_ID_OK;
                end else begin
                    phase_next    = PH_BREAK;
                    result.status = ST_MISMATCH;
                end
            end
            PH_DATA: begin
                if (!length_ok || count_reg >= MAX_LEN) begin
                    phase_next    = PH_BREAK;
                    count_next    = 4'd0;
                    sum_next      = 8'd0;
                    result.status = ST_MISMATCH;
                end else begin
                    store_we      = 1'b1;
                    sum_next      = carry_add(sum_reg, rx_byte);
                    count_next    = count_inc;
                    result.status = ST_STORED;
                    if (count_inc >= data_len_reg) begin
                        phase_next = PH_CHK;
                    end
                end
            end
            PH_CHK: begin
                phase_next = PH_BREAK;
                count_next = 4'd0;
                sum_next   = 8'd0;
                if (rx_byte != ~chk_sum || count_reg == 4'd0) begin
                    result.status = ST_CHK_BAD;
                end else begin
                    result.status = ST_DATA;
                    result.burst  = 1'b1;
                    result.count  = (count_reg > MAX_LEN) ? MAX_LEN : count_reg;
                end
            end
            default: begin
                phase_next = PH_BREAK;
                count_next = 4'd0;
                sum_next   = 8'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_BREAK;
            count_reg    <= 4'd0;
            sum_reg      <= 8'd0;
            ident_reg    <= 6'd0;
            data_len_reg <= MAX_LEN;
            chk_mode_reg <= MODE_AUTO;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_IDENT:    ident_reg    <= cfg_wdata;
                    REG_DATA_LEN: data_len_reg <= cfg_wdata[3:0];
                    REG_CHK_MODE: chk_mode_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    // The store is written only inside a frame; entries are read once written.
    always_ff @(posedge aclk) begin
        if (accept && store_we) begin
            store_reg[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    assign store = store_reg;

endmodule

/* src/lfr_out_stage.sv */
// ----------------------------------------------------------------------------
// LIN frame receiver result stage
// Holds one result descriptor and plays out single results or data bursts.
// ----------------------------------------------------------------------------
module lfr_out_stage
    import lfr_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8,
    parameter int IDX_W          = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  lfr_result_t       result,
    input  logic [7:0]        store [MAX_DATA_BYTES],
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [7:0]        m_data_byte,
    output logic [2:0]        m_byte_index,
    output logic              m_last
);

    logic             valid_reg;
    logic [2:0]       status_reg;
    logic             burst_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic [7:0]       buf_reg [MAX_DATA_BYTES];
    logic             at_last;

    assign at_last = (idx_reg == last_idx_reg);
    assign free    = !valid_reg || (m_ready && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Snapshot of the data store so the next frame can refill it meanwhile.
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg   <= result.status;
            burst_reg    <= result.burst;
            last_idx_reg <= IDX_W'(result.count - 4'd1);
            buf_reg      <= store;
        end
    end

    assign m_valid      = valid_reg;
    assign m_status     = status_reg;
    assign m_data_byte  = burst_reg ? buf_reg[idx_reg] : 8'd0;
    assign m_byte_index = 3'(idx_reg);
    assign m_last       = at_last;

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (idx_reg <= last_idx_reg))
        else $error("burst index beyond last entry");

    a_single_is_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !burst_reg) |-> (last_idx_reg == '0))
        else $error("single result spans more than one transaction");

    a_burst_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_ready && !at_last) |=>
            (valid_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("burst did not advance by one");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !(m_ready && at_last)) |-> !load)
        else $error("result loaded over a pending transaction");
`endif

endmodule

/* src/lin_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// LIN frame receiver top level
// Receives LIN bytes, checks header and checksum, and emits frame data.
// ----------------------------------------------------------------------------
// Usage:
// Each s_ channel transaction carries one byte from the LIN UART on s_rx_byte.
// The block hunts for a break byte, checks the sync byte and the protected ID
// built from the frame identifier register, stores data_length data bytes and
// checks the checksum (classic or enhanced per checksum_mode). Every byte
// produces one m_ channel transaction with a status code, except a good
// checksum, which produces one transaction per stored data byte with m_last
// on the last.
// A result is registered and valid in the cycle after its byte is taken.
// One byte per cycle is taken while m_ready is high and no data burst is
// playing out; the result register holds one byte's results at a time.
// When the receiver stalls, s_ready stays low until the pending result (or
// the last beat of a burst) is taken in the same cycle. Configuration is a
// plain write port; the user must write it only while the block is idle,
// which the block does not enforce. Synchronous active-low reset returns the
// block to the break hunt, restores the register defaults and drops m_valid.
// ----------------------------------------------------------------------------
module lin_frame_receiver_top
    import lfr_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_data_byte,
    output logic [2:0] m_byte_index,
    output logic       m_last
);

    // Index width into the data store; at least one bit.
    localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

    logic        accept;
    logic        free;
    lfr_result_t result;
    logic [7:0]  store [MAX_DATA_BYTES];

    // A byte is taken whenever the result register is empty or drains now.
    assign s_ready = free;
    assign accept  = s_valid && free;

    lfr_frame_fsm #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES),
        .IDX_W          (IDX_W)
    ) u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .result    (result),
        .store     (store)
    );

    lfr_out_stage #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES),
        .IDX_W          (IDX_W)
    ) u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept),
        .result       (result),
        .store        (store),
        .free         (free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last)
    );

endmodule

/* test/lin_frame_receiver_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIN frame receiver testbench
// Sends LIN byte streams into the receiver: directed headers, frames and
// configuration corner cases first, then mostly well-formed random frames
// mixed with line noise and corrupted headers or checksums. A scoreboard
// class tracks the receiver state and queues the results that each accepted
// byte should produce. Every result transaction is then checked field by field.
// ----------------------------------------------------------------------------
module lin_frame_receiver_top_tb;
    import lfr_pkg::*;

    localparam int MAX_DATA_BYTES = 8;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int TIMEOUT_NS     = 5_000_000;

    // Checksum modes that have no name in the package.
    localparam logic [1:0] MODE_CLASSIC  = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        HUNT_BREAK,
        WAIT_SYNC,
        WAIT_PID,
        TAKE_DATA,
        TAKE_CHECKSUM
    } rx_phase_e;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [2:0] byte_index;
        logic       is_last;
    } lin_result_t;

    // The scoreboard mirrors the receiver: it keeps the register values, the
    // frame phase, the stored data bytes and the running checksum, and it
    // holds the results still owed by the block in arrival order.
    class lin_frame_scoreboard;
        logic [5:0]  lin_id;
        logic [3:0]  data_length;
        logic [1:0]  checksum_mode;
        rx_phase_e   phase;
        logic [3:0]  stored_count;
        logic [7:0]  data_sum;
        logic [7:0]  data_store [MAX_DATA_BYTES];
        lin_result_t expected_q [$];
        int          errors;

        function new();
            lin_id        = 6'd0;
            data_length   = 4'd8;
            checksum_mode = MODE_AUTO;
            errors        = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            phase        = HUNT_BREAK;
            stored_count = 4'd0;
            data_sum     = 8'h00;
        endfunction

        function void write_config(logic [5:0] id, logic [3:0] len, logic [1:0] mode);
            lin_id        = id;
            data_length   = len;
            checksum_mode = mode;
        endfunction

        function logic [7:0] protected_id();
            logic p0;
            logic p1;
            p0 = ^{lin_id[4], lin_id[2:0]};
            p1 = ~^{lin_id[5:3], lin_id[1]};
            return {p1, p0, lin_id};
        endfunction

        function logic [7:0] end_around_add(logic [7:0] a, logic [7:0] b);
            logic [8:0] total;
            total = {1'b0, a} + {1'b0, b};
            return total[7:0] + {7'd0, total[8]};
        endfunction

        function bit length_valid();
            return data_length >= 4'd1 && data_length <= MAX_DATA_BYTES;
        endfunction

        // The byte the sender must put after the data to close the frame.
        function logic [7:0] checksum_byte();
            logic       enhanced;
            logic [7:0] total;
            enhanced = (checksum_mode == MODE_ENHANCED) ||
                       (checksum_mode == MODE_AUTO && lin_id < FIRST_DIAG_ID);
            total = enhanced ? end_around_add(data_sum, protected_id()) : data_sum;
            return ~total;
        endfunction

        function void add_expected(lin_result_t r);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void push_status(logic [2:0] st);
            lin_result_t r;
            r = '{status: st, data_byte: 8'h00, byte_index: 3'd0, is_last: 1'b1};
            add_expected(r);
        endfunction

        function void note_byte(logic [7:0] b);
            int          n;
            lin_result_t r;
            case (phase)
                HUNT_BREAK: begin
                    if (b == BREAK_BYTE) begin
                        phase = WAIT_SYNC;
                        push_status(ST_BREAK);
                    end else begin
                        push_status(ST_IGNORED);
                    end
                end
                WAIT_SYNC: begin
                    if (b == SYNC_BYTE) begin
                        phase = WAIT_PID;
                        push_status(ST_SYNC_OK);
                    end else begin
                        restart_hunt();
                        push_status(ST_MISMATCH);
                    end
                end
                WAIT_PID: begin
                    if (b == protected_id() && length_valid()) begin
                        phase        = TAKE_DATA;
                        stored_count = 4'd0;
                        data_sum     = 8'h00;
                        push_status(ST_ID_OK);
                    end else begin
                        restart_hunt();
                        push_status(ST_MISMATCH);
                    end
                end
                TAKE_DATA: begin
                    if (!length_valid() || stored_count >= MAX_DATA_BYTES) begin
                        restart_hunt();
                        push_status(ST_MISMATCH);
                    end else begin
                        data_store[stored_count[2:0]] = b;
                        data_sum     = end_around_add(data_sum, b);
                        stored_count = stored_count + 4'd1;
                        if (stored_count >= data_length) begin
                            phase = TAKE_CHECKSUM;
                        end
                        push_status(ST_STORED);
                    end
                end
                TAKE_CHECKSUM: begin
                    n = (stored_count > MAX_DATA_BYTES) ? MAX_DATA_BYTES : stored_count;
                    if (b != checksum_byte() || n == 0) begin
                        push_status(ST_CHK_BAD);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            r = '{status: ST_DATA,
                                  data_byte: data_store[i],
                                  byte_index: 3'(i),
                                  is_last: (i == n - 1)};
                            add_expected(r);
                        end
                    end
                    restart_hunt();
                end
                default: begin
                    restart_hunt();
                    push_status(ST_IGNORED);
                end
            endcase
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] st, logic [7:0] data, logic [2:0] idx,
                                   logic lst);
            lin_result_t want;
            if (expected_q.size() == 0) begin
                $error("result with status %0d arrived with nothing pending", st);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", {5'd0, want.status}, {5'd0, st});
            compare_field("data_byte", want.data_byte, data);
            compare_field("byte_index", {5'd0, want.byte_index}, {5'd0, idx});
            compare_field("last", {7'd0, want.is_last}, {7'd0, lst});
        endfunction

        function void report_leftover();
            $error("%0d expected results never arrived", expected_q.size());
            errors++;
            expected_q.delete();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_addr;
    logic [5:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_status;
    logic [7:0] m_data_byte;
    logic [2:0] m_byte_index;
    logic       m_last;

    // Percent chance per cycle that the sender holds back or the receiver stalls.
    int send_gap_pct = 38;
    int recv_gap_pct = 75;

    lin_frame_scoreboard sb;

    lin_frame_receiver_top #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_data_byte (m_data_byte),
        .m_byte_index(m_byte_index),
        .m_last      (m_last)
    );

    always #10 aclk = ~aclk;

    // The result side stalls at random, decided anew on every falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    // Both handshakes are sampled at the rising edge. The result is checked
    // before the new byte is noted so that a stray result can never be
    // matched against expectations raised in the same cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_status, m_data_byte, m_byte_index, m_last);
            end
            if (s_valid && s_ready) begin
                sb.note_byte(s_rx_byte);
            end
        end
    end

    // Presents one byte and returns at the falling edge after it was taken.
    // Within this task valid is only lowered while waiting out a random gap, so it
    // never drops while a byte is on offer.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic send_header(input logic [7:0] pid);
        send_byte(BREAK_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(pid);
    endtask

    // The scoreboard already holds the running sum of the data just sent,
    // so the closing byte comes straight from it, corrupted on request.
    task automatic send_checksum(input bit good);
        logic [7:0] chk;
        chk = sb.checksum_byte();
        if (!good) begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        send_byte(chk);
    endtask

    // Stops sending, waits until every owed result has come out, and then
    // waits further so the block is quiet before a register write.
    task automatic drain();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending() != 0) begin
            sb.report_leftover();
        end
        repeat (2) @(negedge aclk);
    endtask

    // Writes all three registers one after another; the block must be idle.
    task automatic set_config(input logic [5:0] id, input logic [3:0] len,
                              input logic [1:0] mode);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_IDENT;
        cfg_wdata <= id;
        @(negedge aclk);
        cfg_addr  <= REG_DATA_LEN;
        cfg_wdata <= {2'b00, len};
        @(negedge aclk);
        cfg_addr  <= REG_CHK_MODE;
        cfg_wdata <= {4'd0, mode};
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.write_config(id, len, mode);
    endtask

    // One random frame. Most are complete and correct; the rest are line
    // noise, a corrupted sync or ID, or a corrupted checksum. Noise bytes
    // are not counted since the receiver mostly ignores them.
    task automatic send_random_frame(output int sent);
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        sent = 0;
        if (roll < 10) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (roll < 15) begin
            send_byte(BREAK_BYTE);
            send_byte(SYNC_BYTE ^ (8'd1 << $urandom_range(0, 7)));
            sent = 2;
        end else if (roll < 22) begin
            send_header(sb.protected_id() ^ (8'd1 << $urandom_range(0, 7)));
            sent = 3;
        end else begin
            send_header(sb.protected_id());
            sent = 3;
            if (sb.length_valid()) begin
                n = sb.data_length;
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                send_checksum(roll >= 32);
                sent = sent + n + 1;
            end
        end
    endtask

    initial begin
        int         frame_bytes;
        int         frames;
        int         sent;
        int         pick;
        logic [5:0] id_val;
        logic [3:0] len_val;

        sb = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_IDENT;
        cfg_wdata <= 6'd0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset registers: ID 0, eight data bytes, automatic checksum.
        // A noise byte, then a break whose sync slot holds another break:
        // that byte is a mismatch and must not restart the header. The next
        // header carries an inverted protected ID.
        send_byte(8'hFF);
        send_byte(BREAK_BYTE);
        send_byte(BREAK_BYTE);
        send_header(~sb.protected_id());
        drain();

        // Highest ID with one all-ones data byte: automatic mode picks the
        // classic checksum for the diagnostic IDs.
        set_config(6'h3F, 4'd1, MODE_AUTO);
        send_header(sb.protected_id());
        send_byte(8'hFF);
        send_checksum(1'b1);
        drain();

        // A length of zero fails the header on an otherwise correct ID.
        set_config(6'h15, 4'd0, MODE_RESERVED);
        send_header(sb.protected_id());
        drain();

        // Longest frame with the enhanced checksum gives the longest burst.
        set_config(6'h15, 4'd8, MODE_ENHANCED);
        send_header(sb.protected_id());
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (6) send_byte(8'($urandom_range(0, 255)));
        send_checksum(1'b1);
        drain();

        // The length drops to the number of bytes already stored in mid-frame: the
        // next data byte ends the data phase and all stored bytes come out.
        // The unused checksum mode acts as classic here.
        set_config(6'h2A, 4'd4, MODE_RESERVED);
        send_header(sb.protected_id());
        send_byte(8'($urandom_range(0, 255)));
        drain();
        set_config(6'h2A, 4'd1, MODE_RESERVED);
        send_byte(8'($urandom_range(0, 255)));
        send_checksum(1'b1);
        drain();

        // The length goes out of range in mid-frame: the next data byte is
        // a header mismatch.
        set_config(6'h2A, 4'd2, MODE_CLASSIC);
        send_header(sb.protected_id());
        send_byte(8'($urandom_range(0, 255)));
        drain();
        set_config(6'h2A, 4'hF, MODE_CLASSIC);
        send_byte(8'($urandom_range(0, 255)));
        drain();

        // Random traffic in three idling patterns: a slow receiver, then a
        // slow sender, then both at full speed. Every few frames the block is
        // drained and given a new ID, length and checksum mode; the length is
        // now and then out of range and the ID often a diagnostic one.
        frame_bytes = 0;
        frames      = 0;
        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_gap_pct = 38;
                    recv_gap_pct = 75;
                end
                1: begin
                    send_gap_pct = 75;
                    recv_gap_pct = 38;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            while (frame_bytes < (stage + 1) * 35) begin
                if (frames % 4 == 0) begin
                    drain();
                    id_val = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63))
                                                         : 6'($urandom_range(0, 63));
                    if ($urandom_range(0, 6) == 0) begin
                        pick    = $urandom_range(0, 7);
                        len_val = (pick == 0) ? 4'd0 : 4'(pick + 8);
                    end else begin
                        len_val = 4'($urandom_range(1, MAX_DATA_BYTES));
                    end
                    set_config(id_val, len_val, 2'($urandom_range(0, 3)));
                end
                send_random_frame(sent);
                frame_bytes = frame_bytes + sent;
                frames++;
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("** lin_frame_receiver_top: PASSED **");
        end else begin
            $display("** lin_frame_receiver_top: FAILED **");
        end
        $finish;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("** lin_frame_receiver_top: FAILED **");
        $finish;
    end

endmodule
